// File: rtl/sdrc_pkg.sv
// Shared types, constants and tables of the stereo dynamic range compressor.
`timescale 1ns / 1ps

package sdrc_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned ENV_W      = SAMPLE_W - 1;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned THR_W      = 23;
  localparam int unsigned MAC_W      = 32;
  localparam int unsigned ADD_W      = 40;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned LOG_W      = 21;
  localparam int unsigned DVD_W      = 37;
  localparam int unsigned QUO_W      = 22;
  localparam int unsigned MANT_W     = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic [GAIN_W-1:0] GainOne = 24'h800000;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] RegThreshold  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] RegRatio      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] RegGainAtt    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] RegGainRel    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] RegEnvAtt     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] RegEnvRel     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] RegMakeup     = 3'd6;

  typedef struct packed {
    logic [THR_W-1:0]  threshold;
    logic [COEF_W-1:0] ratio;
    logic [COEF_W-1:0] gain_att;
    logic [COEF_W-1:0] gain_rel;
    logic [COEF_W-1:0] env_att;
    logic [COEF_W-1:0] env_rel;
    logic [COEF_W-1:0] makeup;
  } cfg_t;

  typedef enum logic [3:0] {
    C_IDLE, C_ENV0, C_ENV1, C_CMP, C_LSQ, C_MULD, C_DIV, C_EXP, C_ESH,
    C_GS0, C_GS1, C_OUT0, C_OUT1, C_FIN
  } core_state_e;

  typedef enum logic [1:0] {
    T_IDLE, T_LEFT, T_RIGHT, T_PUSH
  } top_state_e;

  // 2^(-2^-(k+1)) in Q0.30 for k = 0 .. 11.
  function automatic logic [29:0] exp_tab(input logic [3:0] k);
    logic [29:0] r;
    case (k)
      4'd0:    r = 30'd759250125;
      4'd1:    r = 30'd902905697;
      4'd2:    r = 30'd984625594;
      4'd3:    r = 30'd1028218704;
      4'd4:    r = 30'd1050733756;
      4'd5:    r = 30'd1062175504;
      4'd6:    r = 30'd1067942995;
      4'd7:    r = 30'd1070838491;
      4'd8:    r = 30'd1072289182;
      4'd9:    r = 30'd1073015255;
      4'd10:   r = 30'd1073378480;
      4'd11:   r = 30'd1073560136;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Position of the leading one; zero for a zero input.
  function automatic logic [4:0] lead_one(input logic [ENV_W-1:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < ENV_W; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

endpackage

// File: rtl/sdrc_mac.sv
// Shared multiply-add unit: y = a * b + c.
`timescale 1ns / 1ps

module sdrc_mac (
  input  logic [sdrc_pkg::MAC_W-1:0]  a_i,
  input  logic [sdrc_pkg::MAC_W-1:0]  b_i,
  input  logic [sdrc_pkg::ADD_W-1:0]  c_i,
  output logic [sdrc_pkg::PROD_W-1:0] y_o
);

  assign y_o = (sdrc_pkg::PROD_W'(a_i) * sdrc_pkg::PROD_W'(b_i)) + sdrc_pkg::PROD_W'(c_i);

endmodule

// File: rtl/sdrc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module sdrc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [sdrc_pkg::DVD_W-1:0]  dividend_i,
  input  logic [sdrc_pkg::COEF_W-1:0] divisor_i,
  output logic                        busy_o,
  output logic [sdrc_pkg::QUO_W-1:0]  quotient_o
);

  logic                        busy_q;
  logic [5:0]                  cnt_q;
  logic [sdrc_pkg::DVD_W-1:0]  dvd_q;
  logic [sdrc_pkg::COEF_W-1:0] rem_q, div_q;
  logic [sdrc_pkg::COEF_W:0]   trial;
  logic                        qbit;

  assign trial = {rem_q, dvd_q[sdrc_pkg::DVD_W-1]};
  assign qbit  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(sdrc_pkg::DVD_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // The dividend shifts out at the top while quotient bits enter at the bottom.
      rem_q <= qbit ? sdrc_pkg::COEF_W'(trial - {1'b0, div_q})
                    : trial[sdrc_pkg::COEF_W-1:0];
      dvd_q <= {dvd_q[sdrc_pkg::DVD_W-2:0], qbit};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q[sdrc_pkg::QUO_W-1:0];

endmodule

// File: rtl/sdrc_core.sv
// Per-channel sequencer: envelope, log2, exponent, exp2, gain smoothing and output.
`timescale 1ns / 1ps

module sdrc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  sdrc_pkg::cfg_t                cfg_i,
  input  logic [sdrc_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [sdrc_pkg::ENV_W-1:0]    env_i,
  input  logic [sdrc_pkg::GAIN_W-1:0]   gain_i,
  output logic                          done_o,
  output logic [sdrc_pkg::ENV_W-1:0]    env_o,
  output logic [sdrc_pkg::GAIN_W-1:0]   gain_o,
  output logic [sdrc_pkg::SAMPLE_W-1:0] result_o
);

  sdrc_pkg::core_state_e state_q, state_d;

  logic [sdrc_pkg::SAMPLE_W-1:0] sample_q, result_q, prod_q, mag;
  logic [sdrc_pkg::ENV_W-1:0]    env_q, emag, thr;
  logic [sdrc_pkg::GAIN_W-1:0]   gain_q, target_q, target_e;
  logic [sdrc_pkg::ADD_W-1:0]    acc_q, mac_c;
  logic [sdrc_pkg::MANT_W-1:0]   m_q, p_q, m_next, m_thr, p_sh;
  logic [4:0]                    msb_q;
  logic [15:0]                   frac_q, frac_next;
  logic [3:0]                    cnt_q;
  logic                          log_thr_q;
  logic [sdrc_pkg::LOG_W-1:0]    le_q, d_q, lt_new, d_new;
  logic [sdrc_pkg::QUO_W-1:0]    u_q, quo;
  logic [sdrc_pkg::MAC_W-1:0]    mac_a, mac_b;
  logic [sdrc_pkg::PROD_W-1:0]   mac_y;
  logic [sdrc_pkg::COEF_W-1:0]   a_env, a_gain, ratio, ratio_m;
  logic [31:0]                   sq_t;
  logic [5:0]                    n_int;
  logic [11:0]                   f_bits;
  logic [6:0]                    sh;
  logic [27:0]                   m_full, lim, m_sat;
  logic                          neg, fbit, div_start, div_busy;

  // Operand conditioning.
  assign neg     = sample_q[sdrc_pkg::SAMPLE_W-1];
  assign mag     = neg ? (sdrc_pkg::SAMPLE_W'(0) - sample_q) : sample_q;
  assign emag    = mag[sdrc_pkg::SAMPLE_W-1] ? '1 : mag[sdrc_pkg::ENV_W-1:0];
  assign a_env   = (emag > env_q) ? cfg_i.env_att : cfg_i.env_rel;
  assign a_gain  = (target_q <= gain_q) ? cfg_i.gain_att : cfg_i.gain_rel;
  assign thr     = (cfg_i.threshold == '0) ? sdrc_pkg::ENV_W'(1) : cfg_i.threshold;
  assign ratio   = (cfg_i.ratio < 16'd256) ? 16'd256 : cfg_i.ratio;
  assign ratio_m = ratio - 16'd256;

  // One squaring step of the log2 fraction.
  assign sq_t      = mac_y[61:30];
  assign m_next    = sq_t[31] ? sq_t[31:1] : sq_t[30:0];
  assign frac_next = {frac_q[14:0], sq_t[31]};
  assign lt_new    = {msb_q, frac_next};
  assign d_new     = (le_q > lt_new) ? (le_q - lt_new) : '0;
  assign m_thr     = sdrc_pkg::MANT_W'(thr) << (5'd30 - sdrc_pkg::lead_one(thr));

  // exp2 of the negated exponent.
  assign n_int    = u_q[21:16];
  assign f_bits   = u_q[15:4];
  assign fbit     = f_bits[4'd11 - cnt_q];
  assign sh       = 7'd7 + {1'b0, n_int};
  assign p_sh     = p_q >> sh;
  assign target_e = (n_int >= 6'd31) ? '0 : p_sh[sdrc_pkg::GAIN_W-1:0];

  // Output scaling and saturation.
  assign m_full = mac_y[39:12];
  assign lim    = neg ? 28'h0800000 : 28'h07FFFFF;
  assign m_sat  = (m_full > lim) ? lim : m_full;

  always_comb begin
    mac_a = '0;
    mac_b = '0;
    mac_c = '0;
    unique case (state_q)
      sdrc_pkg::C_ENV0: begin
        mac_a = sdrc_pkg::MAC_W'(a_env);
        mac_b = sdrc_pkg::MAC_W'(env_q);
        mac_c = sdrc_pkg::ADD_W'(32768);
      end
      sdrc_pkg::C_ENV1: begin
        mac_a = sdrc_pkg::MAC_W'(17'h10000 - {1'b0, a_env});
        mac_b = sdrc_pkg::MAC_W'(emag);
        mac_c = acc_q;
      end
      sdrc_pkg::C_LSQ: begin
        mac_a = sdrc_pkg::MAC_W'(m_q);
        mac_b = sdrc_pkg::MAC_W'(m_q);
      end
      sdrc_pkg::C_MULD: begin
        mac_a = sdrc_pkg::MAC_W'(d_q);
        mac_b = sdrc_pkg::MAC_W'(ratio_m);
      end
      sdrc_pkg::C_EXP: begin
        mac_a = sdrc_pkg::MAC_W'(p_q);
        mac_b = sdrc_pkg::MAC_W'(sdrc_pkg::exp_tab(cnt_q));
        mac_c = sdrc_pkg::ADD_W'(40'h0020000000);
      end
      sdrc_pkg::C_GS0: begin
        mac_a = sdrc_pkg::MAC_W'(a_gain);
        mac_b = sdrc_pkg::MAC_W'(gain_q);
        mac_c = sdrc_pkg::ADD_W'(32768);
      end
      sdrc_pkg::C_GS1: begin
        mac_a = sdrc_pkg::MAC_W'(17'h10000 - {1'b0, a_gain});
        mac_b = sdrc_pkg::MAC_W'(target_q);
        mac_c = acc_q;
      end
      sdrc_pkg::C_OUT0: begin
        mac_a = sdrc_pkg::MAC_W'(mag);
        mac_b = sdrc_pkg::MAC_W'(gain_q);
        mac_c = sdrc_pkg::ADD_W'(40'h0000400000);
      end
      sdrc_pkg::C_OUT1: begin
        mac_a = sdrc_pkg::MAC_W'(prod_q);
        mac_b = sdrc_pkg::MAC_W'(cfg_i.makeup);
        mac_c = sdrc_pkg::ADD_W'(2048);
      end
      default: ;
    endcase
  end

  sdrc_mac u_mac (
    .a_i (mac_a),
    .b_i (mac_b),
    .c_i (mac_c),
    .y_o (mac_y)
  );

  assign div_start = (state_q == sdrc_pkg::C_MULD);

  sdrc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mac_y[sdrc_pkg::DVD_W-1:0]),
    .divisor_i  (ratio),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= sdrc_pkg::C_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdrc_pkg::C_IDLE: if (start_i) state_d = sdrc_pkg::C_ENV0;
      sdrc_pkg::C_ENV0: state_d = sdrc_pkg::C_ENV1;
      sdrc_pkg::C_ENV1: state_d = sdrc_pkg::C_CMP;
      sdrc_pkg::C_CMP:  state_d = (env_q < thr) ? sdrc_pkg::C_GS0 : sdrc_pkg::C_LSQ;
      sdrc_pkg::C_LSQ:  if (cnt_q == 4'd15 && log_thr_q) state_d = sdrc_pkg::C_MULD;
      sdrc_pkg::C_MULD: state_d = sdrc_pkg::C_DIV;
      sdrc_pkg::C_DIV:  if (!div_busy) state_d = sdrc_pkg::C_EXP;
      sdrc_pkg::C_EXP:  if (cnt_q == 4'd11) state_d = sdrc_pkg::C_ESH;
      sdrc_pkg::C_ESH:  state_d = sdrc_pkg::C_GS0;
      sdrc_pkg::C_GS0:  state_d = sdrc_pkg::C_GS1;
      sdrc_pkg::C_GS1:  state_d = sdrc_pkg::C_OUT0;
      sdrc_pkg::C_OUT0: state_d = sdrc_pkg::C_OUT1;
      sdrc_pkg::C_OUT1: state_d = sdrc_pkg::C_FIN;
      sdrc_pkg::C_FIN:  state_d = sdrc_pkg::C_IDLE;
      default:          state_d = sdrc_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      sdrc_pkg::C_IDLE: begin
        sample_q <= sample_i;
        env_q    <= env_i;
        gain_q   <= gain_i;
      end
      sdrc_pkg::C_ENV0: acc_q <= mac_y[sdrc_pkg::ADD_W-1:0];
      sdrc_pkg::C_ENV1: env_q <= mac_y[38:16];
      sdrc_pkg::C_CMP: begin
        target_q  <= sdrc_pkg::GainOne;
        m_q       <= sdrc_pkg::MANT_W'(env_q) << (5'd30 - sdrc_pkg::lead_one(env_q));
        msb_q     <= sdrc_pkg::lead_one(env_q);
        frac_q    <= '0;
        cnt_q     <= '0;
        log_thr_q <= 1'b0;
      end
      sdrc_pkg::C_LSQ: begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          if (!log_thr_q) begin
            // Envelope log done; start on the threshold.
            le_q      <= lt_new;
            m_q       <= m_thr;
            msb_q     <= sdrc_pkg::lead_one(thr);
            frac_q    <= '0;
            log_thr_q <= 1'b1;
          end else begin
            d_q <= d_new;
          end
        end else begin
          m_q    <= m_next;
          frac_q <= frac_next;
        end
      end
      sdrc_pkg::C_DIV: begin
        u_q   <= quo;
        p_q   <= sdrc_pkg::MANT_W'(32'h40000000);
        cnt_q <= '0;
      end
      sdrc_pkg::C_EXP: begin
        cnt_q <= cnt_q + 4'd1;
        if (fbit) p_q <= mac_y[60:30];
      end
      sdrc_pkg::C_ESH:  target_q <= target_e;
      sdrc_pkg::C_GS0:  acc_q    <= mac_y[sdrc_pkg::ADD_W-1:0];
      sdrc_pkg::C_GS1:  gain_q   <= mac_y[39:16];
      sdrc_pkg::C_OUT0: prod_q   <= mac_y[46:23];
      sdrc_pkg::C_OUT1: begin
        result_q <= neg ? (sdrc_pkg::SAMPLE_W'(0) - m_sat[sdrc_pkg::SAMPLE_W-1:0])
                        : m_sat[sdrc_pkg::SAMPLE_W-1:0];
      end
      default: ;
    endcase
  end

  assign done_o   = (state_q == sdrc_pkg::C_FIN);
  assign env_o    = env_q;
  assign gain_o   = gain_q;
  assign result_o = result_q;

endmodule

// File: rtl/stereo_dynamic_range_compressor.sv
// Top level of the stereo dynamic range compressor.
`timescale 1ns / 1ps

// Stereo feedforward compressor: one request carries a left and a right sample, and both
// channels are processed one after the other by a single sequencer around one shared
// multiply-add unit and a bit-serial divider. A channel whose envelope stays below the
// threshold skips straight to gain smoothing; above it the channel also runs the two
// 16-step log2 squaring loops, the restoring divide and the 12-step exp2 loop. The input
// is not ready while a pair is being worked on; the finished pair waits in an output
// register, so a new pair can be taken as soon as that register is loaded. Configuration
// writes are always accepted and must only be issued while the block is idle.
module stereo_dynamic_range_compressor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_sample [23:0], right_sample [47:24]
  input  logic [2*sdrc_pkg::SAMPLE_W-1:0]   s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_out [23:0], right_out [47:24]
  output logic [2*sdrc_pkg::SAMPLE_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sdrc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned SW = sdrc_pkg::SAMPLE_W;

  sdrc_pkg::top_state_e state_q, state_d;
  sdrc_pkg::cfg_t       cfg_q;

  logic [sdrc_pkg::ENV_W-1:0]  env_q  [2];
  logic [sdrc_pkg::GAIN_W-1:0] gain_q [2];
  logic [SW-1:0]               left_q, right_q, left_res_q, core_sample, core_result;
  logic                        last_q, start_q, start_d;
  logic [2*SW-1:0]             out_data_q;
  logic                        out_last_q, out_valid_q;
  logic                        ch, core_done, in_acc, push;
  logic [sdrc_pkg::ENV_W-1:0]  core_env;
  logic [sdrc_pkg::GAIN_W-1:0] core_gain;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= 23'd4194304;
      cfg_q.ratio     <= 16'd1024;
      cfg_q.gain_att  <= 16'd62259;
      cfg_q.gain_rel  <= 16'd65209;
      cfg_q.env_att   <= 16'd58982;
      cfg_q.env_rel   <= 16'd65208;
      cfg_q.makeup    <= 16'd4096;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sdrc_pkg::RegThreshold: cfg_q.threshold <= cfg_data_i;
        sdrc_pkg::RegRatio:     cfg_q.ratio     <= cfg_data_i[15:0];
        sdrc_pkg::RegGainAtt:   cfg_q.gain_att  <= cfg_data_i[15:0];
        sdrc_pkg::RegGainRel:   cfg_q.gain_rel  <= cfg_data_i[15:0];
        sdrc_pkg::RegEnvAtt:    cfg_q.env_att   <= cfg_data_i[15:0];
        sdrc_pkg::RegEnvRel:    cfg_q.env_rel   <= cfg_data_i[15:0];
        sdrc_pkg::RegMakeup:    cfg_q.makeup    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == sdrc_pkg::T_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign push          = (state_q == sdrc_pkg::T_PUSH) && (!out_valid_q || m_axis_tready);
  assign ch            = (state_q == sdrc_pkg::T_RIGHT);
  assign core_sample   = ch ? right_q : left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdrc_pkg::T_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

  always_comb begin
    state_d = state_q;
    start_d = 1'b0;
    unique case (state_q)
      sdrc_pkg::T_IDLE: if (in_acc) begin
        state_d = sdrc_pkg::T_LEFT;
        start_d = 1'b1;
      end
      sdrc_pkg::T_LEFT: if (core_done) begin
        state_d = sdrc_pkg::T_RIGHT;
        start_d = 1'b1;
      end
      sdrc_pkg::T_RIGHT: if (core_done) state_d = sdrc_pkg::T_PUSH;
      sdrc_pkg::T_PUSH:  if (push) state_d = sdrc_pkg::T_IDLE;
      default:           state_d = sdrc_pkg::T_IDLE;
    endcase
  end

  sdrc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .cfg_i    (cfg_q),
    .sample_i (core_sample),
    .env_i    (env_q[ch]),
    .gain_i   (gain_q[ch]),
    .done_o   (core_done),
    .env_o    (core_env),
    .gain_o   (core_gain),
    .result_o (core_result)
  );

  // Channel state: envelope resets to zero and smoothed gain to one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q[0]  <= '0;
      env_q[1]  <= '0;
      gain_q[0] <= sdrc_pkg::GainOne;
      gain_q[1] <= sdrc_pkg::GainOne;
    end else if (core_done) begin
      env_q[ch]  <= core_env;
      gain_q[ch] <= core_gain;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      left_q  <= s_axis_tdata[SW-1:0];
      right_q <= s_axis_tdata[2*SW-1:SW];
      last_q  <= s_axis_tlast;
    end
    if (core_done && !ch) left_res_q <= core_result;
    if (push) begin
      out_data_q <= {core_result, left_res_q};
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (push)          out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/sdrc_checker.sv
// Port-level checks of the stereo dynamic range compressor, bound to the top level.
`timescale 1ns / 1ps

module sdrc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [2*sdrc_pkg::SAMPLE_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  // A pair is processed alone: no second request right after one is taken.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request was taken");

  // A result only appears after a processing period, never straight from idle.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while the input side was idle");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result appeared one cycle after the request");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind stereo_dynamic_range_compressor sdrc_checker u_sdrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
